[design/tdm_pkg.sv]
// Package of the task watchdog monitor: sizes, command and slot state codes,
// the slot entry layout and the limit lookup record.
// No dependencies; every other design file refers to it by scoped names.
package tdm_pkg;

  localparam int NUM_TASKS      = 4;
  localparam int NUM_LIMIT_REGS = 4;
  localparam int SLOT_W         = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int MEM_DEPTH      = 1 << SLOT_W;
  localparam int COUNT_W        = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RST_MASK = 3'd4;

  typedef enum logic [3:0] {
    CMD_INIT       = 4'd0,
    CMD_START_MON  = 4'd1,
    CMD_STOP_MON   = 4'd2,
    CMD_PAUSE      = 4'd3,
    CMD_UNPAUSE    = 4'd4,
    CMD_TICK       = 4'd5,
    CMD_START_WDG  = 4'd6,
    CMD_STOP_WDG   = 4'd7,
    CMD_FEED       = 4'd8,
    CMD_FEED_EXT   = 4'd9,
    CMD_SOFT_RESET = 4'd10
  } cmd_t;

  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_STARTED = 2'd1,
    ST_PAUSED  = 2'd2
  } slot_state_t;

  typedef struct packed {
    slot_state_t        state;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // Limit and reset enable of one slot, as seen by the scan.
  typedef struct packed {
    logic [COUNT_W-1:0] limit;
    logic               rst_en;
  } lookup_t;

endpackage

[design/tdm_if.sv]
// Handshake channels of the task watchdog monitor: command in, status out.
// Depends on tdm_pkg for the count width.
interface tdm_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] command;
  logic [1:0] task_slot;

  modport source (output valid, command, task_slot, input ready);
  modport sink   (input valid, command, task_slot, output ready);
endinterface

interface tdm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        feed_main;
  logic                        feed_external;
  logic                        hw_start;
  logic                        expired;
  logic [1:0]                  expired_slot;
  logic [tdm_pkg::COUNT_W-1:0] expired_count;
  logic                        reset_pending;
  logic                        halted;
  logic                        sw_reset_request;

  modport source (output valid, feed_main, feed_external, hw_start, expired, expired_slot,
                  expired_count, reset_pending, halted, sw_reset_request, input ready);
  modport sink   (input valid, feed_main, feed_external, hw_start, expired, expired_slot,
                  expired_count, reset_pending, halted, sw_reset_request, output ready);
endinterface

[design/tdm_cfg_regs.sv]
// Configuration registers of the task watchdog monitor (four slot limits and
// the reset enable mask) and the per-slot lookup used by the scan.
// Depends on tdm_pkg.
module tdm_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tdm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tdm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [tdm_pkg::SLOT_W-1:0]      lk_idx,
  output tdm_pkg::lookup_t                lk
);

  logic [tdm_pkg::COUNT_W-1:0]        limit [tdm_pkg::NUM_LIMIT_REGS];
  logic [tdm_pkg::NUM_LIMIT_REGS-1:0] rst_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < tdm_pkg::NUM_LIMIT_REGS; k++) begin
        limit[k] <= '1;
      end
      rst_mask <= '0;
    end else if (cfg_we) begin
      for (int k = 0; k < tdm_pkg::NUM_LIMIT_REGS; k++) begin
        if (cfg_index == tdm_pkg::CFG_LIMIT0 + tdm_pkg::CFG_IDX_W'(k)) begin
          limit[k] <= cfg_data[tdm_pkg::COUNT_W-1:0];
        end
      end
      if (cfg_index == tdm_pkg::CFG_RST_MASK) begin
        rst_mask <= cfg_data[tdm_pkg::NUM_LIMIT_REGS-1:0];
      end
    end
  end

  // Slots with no limit register of their own never expire and never reset.
  always_comb begin
    lk.limit  = '1;
    lk.rst_en = 1'b0;
    for (int k = 0; k < tdm_pkg::NUM_LIMIT_REGS; k++) begin
      if (32'(lk_idx) == 32'(k)) begin
        lk.limit  = limit[k];
        lk.rst_en = rst_mask[k];
      end
    end
  end

endmodule

[design/task_watchdog_monitor_unit.sv]
// Top level of the task watchdog monitor: command sequencer, slot state
// memory and result register. Depends on tdm_pkg, tdm_if and tdm_cfg_regs.
//
// Usage. Commands arrive as beats on in_ch (command, task_slot); every
// accepted beat produces exactly one status beat on out_ch, in order.
// Configuration (four slot limits, then the reset enable mask at index 4)
// is written through cfg_we / cfg_index / cfg_data while the block is idle.
//
// Flow. One command is in flight at a time. Commands that only touch flags
// go from acceptance straight to the result; slot commands pass through
// memory read, write back and result. A tick while armed walks the slot
// memory one entry per cycle and stops early when a slot expires. The next
// command is taken once the status beat is loaded, so a new command is
// accepted only after the previous one has finished.
//
// Reset. rst (synchronous, active high) stops every slot, clears all counts
// through per-entry valid bits, disarms the block, clears the pending and
// halted flags and restores the limits to 65535 and the mask to zero.
//
// Back-pressure. The status beat sits in an output register; the next
// command is accepted meanwhile and its result waits until out_ch drains.
module task_watchdog_monitor_unit (
  input  logic                           clk,
  input  logic                           rst,
  tdm_in_if.sink                         in_ch,
  tdm_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tdm_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SLOT = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } fsm_t;

  fsm_t state;
  fsm_t accept_state_next;

  // Global flags.
  logic armed;
  logic pending_reset;
  logic stuck;

  // Command under work and the slot it addresses or the scan position.
  tdm_pkg::cmd_t               cmd_q;
  logic [tdm_pkg::SLOT_W-1:0]  cur_idx;

  // Result fields collected while the command runs.
  logic                        res_feed_main;
  logic                        res_feed_ext;
  logic                        res_hw_start;
  logic                        res_expired;
  logic [1:0]                  res_slot;
  logic [tdm_pkg::COUNT_W-1:0] res_count;
  logic                        res_sw_req;

  // Slot memory. Valid bits stand in for clearing: an entry whose state bit
  // is clear reads as stopped, one whose count bit is clear reads as zero.
  tdm_pkg::entry_t               mem [tdm_pkg::MEM_DEPTH];
  tdm_pkg::entry_t               rd_data;
  logic [tdm_pkg::SLOT_W-1:0]    rd_addr;
  logic                          mem_we;
  tdm_pkg::entry_t               mem_wdata;
  logic [tdm_pkg::MEM_DEPTH-1:0] st_vld;
  logic [tdm_pkg::MEM_DEPTH-1:0] cnt_vld;

  tdm_pkg::slot_state_t         ent_state;
  logic [tdm_pkg::COUNT_W-1:0]  ent_count;
  tdm_pkg::lookup_t             lk;

  logic                         in_fire;
  tdm_pkg::cmd_t                in_cmd;
  logic                         slot_ok;
  logic [tdm_pkg::COUNT_W-1:0]  cnt_inc;
  logic                         scan_started;
  logic                         scan_hit;
  logic                         scan_last;
  logic                         out_free;

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_cmd      = tdm_pkg::cmd_t'(in_ch.command);
  assign slot_ok     = 32'(in_ch.task_slot) < tdm_pkg::NUM_TASKS;
  assign out_free    = !out_ch.valid || out_ch.ready;

  tdm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lk_idx    (cur_idx),
    .lk        (lk)
  );

  // The read address names the entry that comes under work next: at acceptance
  // it is the addressed slot (or slot zero for a tick), during the scan it
  // is the next slot, so reads and write-backs never meet on one entry.
  always_comb begin
    if (state == S_SCAN) begin
      rd_addr = cur_idx + tdm_pkg::SLOT_W'(1);
    end else if (in_cmd == tdm_pkg::CMD_TICK) begin
      rd_addr = '0;
    end else begin
      rd_addr = tdm_pkg::SLOT_W'(in_ch.task_slot);
    end
  end

  // Where an accepted command goes next: unless the block is halted, slot commands
  // visit the memory and an armed tick walks it; everything else reports at once.
  always_comb begin
    accept_state_next = S_DONE;
    if (!stuck) begin
      if (in_cmd inside {tdm_pkg::CMD_START_MON, tdm_pkg::CMD_STOP_MON,
                         tdm_pkg::CMD_PAUSE, tdm_pkg::CMD_UNPAUSE}) begin
        if (slot_ok) begin
          accept_state_next = S_SLOT;
        end
      end else if (in_cmd == tdm_pkg::CMD_TICK && armed) begin
        accept_state_next = S_SCAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (mem_we) begin
      mem[cur_idx] <= mem_wdata;
    end
  end

  assign ent_state    = st_vld[cur_idx] ? rd_data.state : tdm_pkg::ST_STOPPED;
  assign ent_count    = cnt_vld[cur_idx] ? rd_data.count : '0;
  assign cnt_inc      = ent_count + tdm_pkg::COUNT_W'(1);
  assign scan_started = (ent_state == tdm_pkg::ST_STARTED);
  assign scan_hit     = scan_started && (cnt_inc > lk.limit);
  assign scan_last    = (cur_idx == tdm_pkg::SLOT_W'(tdm_pkg::NUM_TASKS - 1));

  // Write-back of the entry under work.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '{state: ent_state, count: ent_count};
    if (state == S_SLOT) begin
      case (cmd_q)
        tdm_pkg::CMD_START_MON: begin
          mem_we    = (ent_state != tdm_pkg::ST_STARTED);
          mem_wdata = '{state: tdm_pkg::ST_STARTED, count: '0};
        end
        tdm_pkg::CMD_STOP_MON: begin
          mem_we    = (ent_state != tdm_pkg::ST_STOPPED);
          mem_wdata = '{state: tdm_pkg::ST_STOPPED, count: '0};
        end
        tdm_pkg::CMD_PAUSE: begin
          mem_we          = (ent_state == tdm_pkg::ST_STARTED);
          mem_wdata.state = tdm_pkg::ST_PAUSED;
        end
        tdm_pkg::CMD_UNPAUSE: begin
          mem_we          = (ent_state == tdm_pkg::ST_PAUSED);
          mem_wdata.state = tdm_pkg::ST_STARTED;
        end
        default: mem_we = 1'b0;
      endcase
    end else if (state == S_SCAN) begin
      mem_we          = scan_started;
      mem_wdata.count = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      armed         <= 1'b0;
      pending_reset <= 1'b0;
      stuck         <= 1'b0;
      st_vld        <= '0;
      cnt_vld       <= '0;
      out_ch.valid  <= 1'b0;
    end else begin
      // A beat taken while the next one is being loaded is replaced below.
      if (out_ch.valid && out_ch.ready && state != S_DONE) begin
        out_ch.valid <= 1'b0;
      end
      if (mem_we) begin
        st_vld[cur_idx]  <= 1'b1;
        cnt_vld[cur_idx] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            cmd_q         <= in_cmd;
            cur_idx       <= rd_addr;
            res_feed_main <= !stuck && armed && !pending_reset &&
                             (in_cmd == tdm_pkg::CMD_FEED);
            res_feed_ext  <= !stuck && armed && !pending_reset &&
                             (in_cmd == tdm_pkg::CMD_FEED_EXT);
            res_hw_start  <= !stuck && (in_cmd == tdm_pkg::CMD_START_WDG);
            res_expired   <= 1'b0;
            res_slot      <= '0;
            res_count     <= '0;
            res_sw_req    <= !stuck && (in_cmd == tdm_pkg::CMD_SOFT_RESET);
            state         <= accept_state_next;
            // A halted block ignores every command until reset.
            if (!stuck) begin
              unique case (in_cmd)
                tdm_pkg::CMD_INIT: begin
                  st_vld        <= '0;
                  cnt_vld       <= '0;
                  pending_reset <= 1'b0;
                  armed         <= 1'b0;
                end
                tdm_pkg::CMD_START_WDG: begin
                  cnt_vld <= '0;
                  armed   <= 1'b1;
                end
                tdm_pkg::CMD_STOP_WDG: begin
                  armed <= 1'b0;
                end
                tdm_pkg::CMD_FEED: begin
                  // Feeding an armed block with a reset pending halts it.
                  if (armed && pending_reset) begin
                    stuck <= 1'b1;
                  end
                end
                tdm_pkg::CMD_SOFT_RESET: begin
                  pending_reset <= 1'b1;
                end
                default: ;
              endcase
            end
          end
        end
        S_SLOT: begin
          state <= S_DONE;
        end
        S_SCAN: begin
          // The first expired slot ends the scan and decides the pending
          // flag; a scan that finds none clears it.
          if (scan_hit || scan_last) begin
            pending_reset <= scan_hit && lk.rst_en;
            if (scan_hit && lk.rst_en) begin
              stuck <= 1'b1;
            end else begin
              res_feed_main <= 1'b1;
            end
            res_expired <= scan_hit;
            if (scan_hit) begin
              res_slot  <= 2'(cur_idx);
              res_count <= cnt_inc;
            end
            state <= S_DONE;
          end else begin
            cur_idx <= cur_idx + tdm_pkg::SLOT_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_ch.valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Status beat payload, loaded together with out_ch.valid.
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_ch.feed_main        <= res_feed_main;
      out_ch.feed_external    <= res_feed_ext;
      out_ch.hw_start         <= res_hw_start;
      out_ch.expired          <= res_expired;
      out_ch.expired_slot     <= res_slot;
      out_ch.expired_count    <= res_count;
      out_ch.reset_pending    <= pending_reset;
      out_ch.halted           <= stuck;
      out_ch.sw_reset_request <= res_sw_req;
    end
  end

`ifndef NO_ASSERTIONS
  // Once halted, only reset releases the block.
  a_halt_sticks: assert property (@(posedge clk) disable iff (rst) stuck |=> stuck)
    else $error("halted flag cleared without reset");

  // An expiry either feeds the watchdog or leaves a reset pending, never both.
  a_expiry_outcome: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.expired) |-> (out_ch.feed_main != out_ch.reset_pending))
    else $error("expiry result inconsistent with pending reset");

  // A beat that feeds the watchdog never reports a halted block.
  a_no_feed_halted: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.feed_main && out_ch.halted))
    else $error("feed reported while halted");

  a_fsm_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");
`endif

endmodule

[verif/task_watchdog_monitor_unit_tb.sv]
// Self-checking testbench for task_watchdog_monitor_unit: drives command beats,
// predicts each status beat and compares it field by field.
// Depends on tdm_pkg, tdm_if and the RTL of the block.
`timescale 1ns / 100ps

module task_watchdog_monitor_unit_tb;

  localparam int CLK_PERIOD  = 8;
  localparam int MAX_CYCLES  = 200_000;
  localparam int TAIL_CYCLES = 4 * (tdm_pkg::NUM_TASKS + 2);
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 610;
  localparam int MAX_REPORTS = 10;

  // Command codes that the block decodes as nothing at all.
  localparam logic [3:0] CMD_UNUSED_LO = 4'd11;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  // One status beat, as the block presents it on out_ch.
  typedef struct packed {
    logic                        feed_main;
    logic                        feed_external;
    logic                        hw_start;
    logic                        expired;
    logic [1:0]                  expired_slot;
    logic [tdm_pkg::COUNT_W-1:0] expired_count;
    logic                        reset_pending;
    logic                        halted;
    logic                        sw_reset_request;
  } status_t;

  // Watchdog state mirror plus the queue of status beats still owed by the block.
  class wdg_status_board;
    tdm_pkg::slot_state_t               state_of  [tdm_pkg::NUM_TASKS];
    logic [tdm_pkg::COUNT_W-1:0]        count_of  [tdm_pkg::NUM_TASKS];
    logic [tdm_pkg::COUNT_W-1:0]        limit_reg [tdm_pkg::NUM_LIMIT_REGS];
    logic [tdm_pkg::NUM_LIMIT_REGS-1:0] rst_mask;
    bit                                 armed;
    bit                                 pending;
    bit                                 stuck;
    status_t                            due_status [$];
    int                                 errors;
    int                                 beats;

    function new();
      for (int i = 0; i < tdm_pkg::NUM_LIMIT_REGS; i++) limit_reg[i] = '1;
      rst_mask = '0;
      clear_slots();
      armed   = 1'b0;
      pending = 1'b0;
      stuck   = 1'b0;
      errors  = 0;
      beats   = 0;
    endfunction

    function void clear_slots();
      for (int i = 0; i < tdm_pkg::NUM_TASKS; i++) begin
        state_of[i] = tdm_pkg::ST_STOPPED;
        count_of[i] = '0;
      end
    endfunction

    function void write_reg(int idx, logic [tdm_pkg::CFG_DATA_W-1:0] val);
      if (idx < tdm_pkg::NUM_LIMIT_REGS) limit_reg[idx] = val[tdm_pkg::COUNT_W-1:0];
      else if (idx == tdm_pkg::CFG_RST_MASK) rst_mask = val[tdm_pkg::NUM_LIMIT_REGS-1:0];
    endfunction

    function logic [tdm_pkg::COUNT_W-1:0] limit_of(int s);
      if (s < tdm_pkg::NUM_LIMIT_REGS) return limit_reg[s];
      return '1;
    endfunction

    function bit rst_en_of(int s);
      if (s < tdm_pkg::NUM_LIMIT_REGS) return rst_mask[s];
      return 1'b0;
    endfunction

    // Slot that the next armed tick would report, or -1 when none expires.
    function int next_expiry();
      logic [tdm_pkg::COUNT_W-1:0] nxt;
      for (int i = 0; i < tdm_pkg::NUM_TASKS; i++) begin
        nxt = count_of[i] + 1'b1;
        if (state_of[i] == tdm_pkg::ST_STARTED && nxt > limit_of(i)) return i;
      end
      return -1;
    endfunction

    function bit would_halt(logic [3:0] code);
      int e;
      if (stuck) return 1'b0;
      if (code == tdm_pkg::CMD_FEED) return armed && pending;
      if (code == tdm_pkg::CMD_TICK && armed) begin
        e = next_expiry();
        return (e >= 0) && rst_en_of(e);
      end
      return 1'b0;
    endfunction

    function void accept_command(logic [3:0] code, logic [1:0] slot);
      status_t exp;
      int      s;
      bit      slot_ok;
      bit      want;
      exp     = '0;
      s       = slot;
      slot_ok = s < tdm_pkg::NUM_TASKS;
      want    = 1'b0;
      if (!stuck) begin
        case (code)
          tdm_pkg::CMD_INIT: begin
            clear_slots();
            pending = 1'b0;
            armed   = 1'b0;
          end
          tdm_pkg::CMD_START_MON: begin
            if (slot_ok && state_of[s] != tdm_pkg::ST_STARTED) begin
              count_of[s] = '0;
              state_of[s] = tdm_pkg::ST_STARTED;
            end
          end
          tdm_pkg::CMD_STOP_MON: begin
            if (slot_ok && state_of[s] != tdm_pkg::ST_STOPPED) begin
              count_of[s] = '0;
              state_of[s] = tdm_pkg::ST_STOPPED;
            end
          end
          tdm_pkg::CMD_PAUSE: begin
            if (slot_ok && state_of[s] == tdm_pkg::ST_STARTED)
              state_of[s] = tdm_pkg::ST_PAUSED;
          end
          tdm_pkg::CMD_UNPAUSE: begin
            if (slot_ok && state_of[s] == tdm_pkg::ST_PAUSED)
              state_of[s] = tdm_pkg::ST_STARTED;
          end
          tdm_pkg::CMD_TICK: begin
            if (armed) begin
              for (int i = 0; i < tdm_pkg::NUM_TASKS; i++) begin
                if (state_of[i] == tdm_pkg::ST_STARTED) begin
                  count_of[i] = count_of[i] + 1'b1;
                  if (count_of[i] > limit_of(i)) begin
                    want              = rst_en_of(i);
                    exp.expired       = 1'b1;
                    exp.expired_slot  = 2'(i);
                    exp.expired_count = count_of[i];
                    break;
                  end
                end
              end
              pending = want;
              if (!pending) exp.feed_main = 1'b1;
              else stuck = 1'b1;
            end
          end
          tdm_pkg::CMD_START_WDG: begin
            for (int i = 0; i < tdm_pkg::NUM_TASKS; i++) count_of[i] = '0;
            exp.hw_start = 1'b1;
            armed        = 1'b1;
          end
          tdm_pkg::CMD_STOP_WDG: armed = 1'b0;
          tdm_pkg::CMD_FEED: begin
            if (armed) begin
              if (!pending) exp.feed_main = 1'b1;
              else stuck = 1'b1;
            end
          end
          tdm_pkg::CMD_FEED_EXT: begin
            if (armed && !pending) exp.feed_external = 1'b1;
          end
          tdm_pkg::CMD_SOFT_RESET: begin
            pending              = 1'b1;
            exp.sw_reset_request = 1'b1;
          end
          default: ;
        endcase
      end
      exp.reset_pending = pending;
      exp.halted        = stuck;
      due_status.push_back(exp);
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void compare(string name, logic [tdm_pkg::COUNT_W-1:0] e,
                          logic [tdm_pkg::COUNT_W-1:0] a);
      if (a !== e)
        fail($sformatf("status beat %0d: %s expected %0d, got %0d", beats, name, e, a));
    endfunction

    function void check_status(status_t got);
      status_t exp;
      beats++;
      if (due_status.size() == 0) begin
        fail($sformatf("status beat %0d arrived with no command outstanding", beats));
        return;
      end
      exp = due_status.pop_front();
      compare("feed_main",        exp.feed_main,        got.feed_main);
      compare("feed_external",    exp.feed_external,    got.feed_external);
      compare("hw_start",         exp.hw_start,         got.hw_start);
      compare("expired",          exp.expired,          got.expired);
      compare("expired_slot",     exp.expired_slot,     got.expired_slot);
      compare("expired_count",    exp.expired_count,    got.expired_count);
      compare("reset_pending",    exp.reset_pending,    got.reset_pending);
      compare("halted",           exp.halted,           got.halted);
      compare("sw_reset_request", exp.sw_reset_request, got.sw_reset_request);
    endfunction

    function int outstanding();
      return due_status.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [tdm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tdm_pkg::CFG_DATA_W-1:0] cfg_data;

  tdm_in_if  in_ch ();
  tdm_out_if out_ch ();

  task_watchdog_monitor_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wdg_status_board sb;

  // Idle odds in percent for each side, changed by the main sequence per phase.
  int send_idle_pct;
  int recv_idle_pct;

  // The main sequence bumps hold_asked; the ready process answers with a long
  // stall that it counts down itself.
  int hold_asked;
  int hold_given;
  int hold_left;

  // Register values to be programmed at the next idle point.
  logic [tdm_pkg::COUNT_W-1:0]        lim_plan [tdm_pkg::NUM_LIMIT_REGS];
  logic [tdm_pkg::NUM_LIMIT_REGS-1:0] mask_plan;

  int cycles;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Hard stop in case the block hangs; sized several times over the slowest
  // legal run, with both sides idling and the long receiver hold.
  initial begin
    cycles = 0;
    while (cycles < MAX_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Status receiver: ready changes only on the falling edge. During a
  // requested hold it stays low so the single result register fills and
  // the block has to stall its command input.
  initial begin
    out_ch.ready = 1'b0;
    hold_given   = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_given) begin
        hold_given = hold_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every status beat taken on a rising edge is checked against the oldest
  // prediction.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_status('{out_ch.feed_main, out_ch.feed_external, out_ch.hw_start,
                        out_ch.expired, out_ch.expired_slot, out_ch.expired_count,
                        out_ch.reset_pending, out_ch.halted, out_ch.sw_reset_request});
  end

  // Offers one command beat and returns on the falling edge after it was
  // taken. Idle gaps carry junk payload with valid low.
  task automatic send_command(logic [3:0] code, logic [1:0] slot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid     <= 1'b0;
      in_ch.command   <= 4'($urandom);
      in_ch.task_slot <= 2'($urandom);
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= code;
    in_ch.task_slot <= slot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.accept_command(code, slot);
    @(negedge clk);
  endtask

  // Stops offering and waits until the block has answered every command.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes all limit registers and the mask from the plan; only called while
  // nothing is in flight.
  task automatic program_regs();
    for (int i = 0; i < tdm_pkg::NUM_LIMIT_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= tdm_pkg::CFG_IDX_W'(tdm_pkg::CFG_LIMIT0 + i);
      cfg_data  <= lim_plan[i];
      sb.write_reg(i, lim_plan[i]);
      @(negedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_index <= tdm_pkg::CFG_RST_MASK;
    cfg_data  <= tdm_pkg::CFG_DATA_W'(mask_plan);
    sb.write_reg(tdm_pkg::CFG_RST_MASK, tdm_pkg::CFG_DATA_W'(mask_plan));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic plan_small_limits(int hi);
    for (int i = 0; i < tdm_pkg::NUM_LIMIT_REGS; i++)
      lim_plan[i] = tdm_pkg::COUNT_W'($urandom_range(hi));
  endtask

  // Weighted command mix: mostly ticks and slot management so that counts
  // really climb past small limits, with a share of noise and unused codes.
  // Anything that would halt the block is drawn again, since halting is
  // permanent and is saved for the last phase.
  function automatic void pick_command(output logic [3:0] code, output logic [1:0] slot);
    int r;
    do begin
      r    = $urandom_range(99);
      slot = 2'($urandom_range(3));
      if (r < 30)      code = tdm_pkg::CMD_TICK;
      else if (r < 40) code = tdm_pkg::CMD_START_MON;
      else if (r < 46) code = tdm_pkg::CMD_STOP_MON;
      else if (r < 52) code = tdm_pkg::CMD_PAUSE;
      else if (r < 58) code = tdm_pkg::CMD_UNPAUSE;
      else if (r < 66) code = tdm_pkg::CMD_START_WDG;
      else if (r < 69) code = tdm_pkg::CMD_STOP_WDG;
      else if (r < 78) code = tdm_pkg::CMD_FEED;
      else if (r < 85) code = tdm_pkg::CMD_FEED_EXT;
      else if (r < 90) code = tdm_pkg::CMD_SOFT_RESET;
      else if (r < 93) code = tdm_pkg::CMD_INIT;
      else if (r < 96) code = 4'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
      else             code = 4'($urandom_range(CMD_UNUSED_HI));
    end while (sb.would_halt(code));
  endfunction

  task automatic send_random(int n);
    logic [3:0] code;
    logic [1:0] slot;
    repeat (n) begin
      pick_command(code, slot);
      send_command(code, slot);
    end
  endtask

  initial begin
    sb              = new();
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.command   = '0;
    in_ch.task_slot = '0;
    hold_asked      = 0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed part. Slot two has a zero limit so it expires on its first
    // count, slot three keeps the top limit and never expires.
    lim_plan[0] = 16'd2;
    lim_plan[1] = 16'd5;
    lim_plan[2] = 16'd0;
    lim_plan[3] = 16'hFFFF;
    mask_plan   = '0;
    program_regs();
    send_idle_pct = 20;
    recv_idle_pct = 20;

    // While disarmed, ticks and feeds do nothing; an unused code is ignored.
    send_command(tdm_pkg::CMD_TICK, 2'd0);
    send_command(tdm_pkg::CMD_FEED, 2'd1);
    send_command(tdm_pkg::CMD_FEED_EXT, 2'd2);
    send_command(CMD_UNUSED_HI, 2'd3);
    send_command(tdm_pkg::CMD_START_MON, 2'd0);
    send_command(tdm_pkg::CMD_START_MON, 2'd1);
    send_command(tdm_pkg::CMD_START_MON, 2'd2);
    send_command(tdm_pkg::CMD_START_MON, 2'd3);
    // Starting a slot that already runs must not clear its count.
    send_command(tdm_pkg::CMD_START_MON, 2'd0);
    send_command(tdm_pkg::CMD_PAUSE, 2'd3);
    send_command(tdm_pkg::CMD_START_WDG, 2'd0);
    // First armed tick: slot two crosses its zero limit and ends the scan.
    send_command(tdm_pkg::CMD_TICK, 2'd1);
    send_command(tdm_pkg::CMD_PAUSE, 2'd2);
    send_command(tdm_pkg::CMD_TICK, 2'd2);
    send_command(tdm_pkg::CMD_UNPAUSE, 2'd2);
    send_command(tdm_pkg::CMD_UNPAUSE, 2'd1);
    // A soft reset raises the pending flag; feed_ext is then refused and the
    // next tick overwrites the flag with the expired slot's enable bit.
    send_command(tdm_pkg::CMD_SOFT_RESET, 2'd0);
    send_command(tdm_pkg::CMD_FEED_EXT, 2'd3);
    send_command(tdm_pkg::CMD_TICK, 2'd0);
    send_command(tdm_pkg::CMD_FEED, 2'd0);
    send_command(tdm_pkg::CMD_FEED_EXT, 2'd1);
    send_command(tdm_pkg::CMD_STOP_MON, 2'd1);
    send_command(tdm_pkg::CMD_PAUSE, 2'd1);
    send_command(tdm_pkg::CMD_STOP_WDG, 2'd2);
    send_command(tdm_pkg::CMD_TICK, 2'd3);
    send_command(tdm_pkg::CMD_INIT, 2'd2);
    send_command(CMD_UNUSED_LO, 2'd1);
    wait_drained();

    // Random phase with a slow receiver. Some slots have reset enabled; ticks
    // that would expire them are redrawn, so they only pile up counts.
    plan_small_limits(12);
    mask_plan     = tdm_pkg::NUM_LIMIT_REGS'($urandom_range(14, 1));
    send_idle_pct = 20;
    recv_idle_pct = 79;
    program_regs();
    send_command(tdm_pkg::CMD_INIT, 2'd0);
    send_random(PHASE_ITEMS);
    wait_drained();

    // Random phase with a slow sender and the limit extremes.
    plan_small_limits(30);
    lim_plan[0]   = 16'd0;
    lim_plan[1]   = 16'hFFFF;
    mask_plan     = '0;
    send_idle_pct = 79;
    recv_idle_pct = 20;
    program_regs();
    send_random(PHASE_ITEMS);
    wait_drained();

    // Back-to-back phase. Midway the receiver stalls for a long stretch while
    // commands keep coming, so the block backs up and refuses input.
    plan_small_limits(20);
    mask_plan     = tdm_pkg::NUM_LIMIT_REGS'($urandom_range(14, 1));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs();
    send_random(PHASE_ITEMS / 3);
    hold_asked++;
    send_random(PHASE_ITEMS - PHASE_ITEMS / 3);
    wait_drained();

    // Final phase: halt the block for good, either through a reset-enabled
    // expiry or through a feed with a reset pending, then show that every
    // command is ignored afterwards.
    lim_plan[0]   = 16'hFFFF;
    lim_plan[1]   = 16'd1;
    mask_plan     = '1;
    send_idle_pct = 20;
    recv_idle_pct = 20;
    program_regs();
    send_command(tdm_pkg::CMD_INIT, 2'd0);
    if ($urandom_range(1)) begin
      send_command(tdm_pkg::CMD_START_MON, 2'd1);
      send_command(tdm_pkg::CMD_START_WDG, 2'd0);
      send_command(tdm_pkg::CMD_TICK, 2'd0);
      send_command(tdm_pkg::CMD_TICK, 2'd0);
    end else begin
      send_command(tdm_pkg::CMD_START_WDG, 2'd0);
      send_command(tdm_pkg::CMD_SOFT_RESET, 2'd0);
      send_command(tdm_pkg::CMD_FEED, 2'd0);
    end
    repeat (30) send_command(4'($urandom_range(CMD_UNUSED_HI)), 2'($urandom_range(3)));
    wait_drained();

    // Let any stray beat surface before judging.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
